// ===== design/reliable_packet_ack_tracker_defines.svh =====
// Assertion macros for the reliable packet ack tracker
`ifndef RELIABLE_PACKET_ACK_TRACKER_DEFINES_SVH
`define RELIABLE_PACKET_ACK_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define RPAT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rpat assertion failed");
`define RPAT_ASSERT_IMPLY(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("rpat implication failed");
`else
`define RPAT_ASSERT(label, clk, rstn, prop)
`define RPAT_ASSERT_IMPLY(label, clk, rstn, a, c)
`endif
`endif

// ===== design/rpat_pkg.sv =====
// Types, constants and control structs of the reliable packet ack tracker
package rpat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ACK_WINDOW  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SEQ_W       = 32;
    localparam int TIME_W      = 48;
    localparam int CNT_W       = 8;
    localparam int INTV_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] ACT_SENT  = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_RESEND  = 2'd1;
    localparam logic [1:0] KIND_GIVE_UP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESENDS = CFG_IDX_W'(1);

    localparam logic [INTV_W-1:0] INTERVAL_RESET = INTV_W'(1000);
    localparam logic [CNT_W-1:0]  MAX_RESET      = CNT_W'(5);

    typedef struct packed {
        logic [1:0]        action;
        logic [SEQ_W-1:0]  sequence_req;
        logic [31:0]       ack_bits;
        logic              reliable;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] out_sequence;
        logic [CNT_W-1:0] attempt;
        logic             table_full;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic       load_req;
        logic       scan_start;
        logic       scan_next;
        logic       send_note;
        logic       send_write;
        logic       ack_clear;
        logic       clear_all;
        logic       tick_start;
        logic       pick_note;
        logic       pick_go;
        logic       eval_visit;
        logic       resend_update;
        logic       give_up;
        logic       emit;
        logic [1:0] emit_kind;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       reliable;
        logic       idx_last;
        logic       have_pick;
        logic       due;
        logic       limit_hit;
        logic       limit_next;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== design/rpat_dp.sv =====
// Datapath: entry table, scan index, request and result registers, config
module rpat_dp import rpat_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  req_t                  s_payload,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctl_cmd_t              cmd,
    output dp_status_t            status,
    input  logic                  m_ready,
    output logic                  m_valid,
    output rsp_t                  m_payload
);

    req_t                    req_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [TABLE_DEPTH-1:0]  visited_reg;
    logic [SEQ_W-1:0]        seq_reg  [TABLE_DEPTH];
    logic [TIME_W-1:0]       time_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]        cnt_reg  [TABLE_DEPTH];
    logic                    match_found_reg;
    logic [IDX_W-1:0]        match_idx_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic                    full_reg;
    logic                    pick_have_reg;
    logic [IDX_W-1:0]        pick_idx_reg;
    logic [SEQ_W-1:0]        pick_seq_reg;
    logic [INTV_W-1:0]       interval_reg;
    logic [CNT_W-1:0]        max_reg;
    logic                    out_valid_reg;
    rsp_t                    out_reg;

    logic [SEQ_W-1:0]  cur_seq;
    logic [TIME_W-1:0] cur_time;
    logic [CNT_W-1:0]  cur_cnt;
    logic              cur_valid;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SEQ_W-1:0]  diff;
    logic [4:0]        bit_sel;
    logic              acked;
    logic [TIME_W-1:0] elapsed;
    logic              out_free;
    logic [IDX_W-1:0]  slot;
    rsp_t              emit_val;

    assign cur_seq   = seq_reg[idx_reg];
    assign cur_time  = time_reg[idx_reg];
    assign cur_cnt   = cnt_reg[idx_reg];
    assign cur_valid = valid_reg[idx_reg];
    assign cnt_inc   = cur_cnt + CNT_W'(1);

    assign diff    = req_reg.sequence_req - cur_seq;
    assign bit_sel = diff[4:0] - 5'd1;
    assign acked   = (cur_seq <= req_reg.sequence_req) &&
                     ((diff == '0) ||
                      ((diff <= SEQ_W'(ACK_WINDOW)) && req_reg.ack_bits[bit_sel]));

    assign elapsed  = (req_reg.now_ms > cur_time) ? (req_reg.now_ms - cur_time) : '0;
    assign out_free = !out_valid_reg || m_ready;
    assign slot     = match_found_reg ? match_idx_reg : free_idx_reg;

    always_comb begin
        emit_val = '0;
        emit_val.kind = cmd.emit_kind;
        case (cmd.emit_kind)
            KIND_RESEND: begin
                emit_val.out_sequence = cur_seq;
                emit_val.attempt      = cnt_inc;
            end
            KIND_GIVE_UP: begin
                emit_val.out_sequence = cur_seq;
                emit_val.attempt      = cur_cnt;
            end
            default: begin
                emit_val.table_full = full_reg;
                emit_val.last       = 1'b1;
            end
        endcase
    end

    assign status.action     = req_reg.action;
    assign status.reliable   = req_reg.reliable;
    assign status.idx_last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign status.have_pick  = pick_have_reg;
    assign status.due        = (elapsed >= TIME_W'(interval_reg));
    assign status.limit_hit  = (cur_cnt >= max_reg);
    assign status.limit_next = (cnt_inc >= max_reg);
    assign status.out_free   = out_free;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            interval_reg  <= INTERVAL_RESET;
            max_reg       <= MAX_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_INTERVAL) begin
                    interval_reg <= cfg_data;
                end else if (cfg_index == CFG_MAX_RESENDS) begin
                    max_reg <= cfg_data[CNT_W-1:0];
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.send_write && (match_found_reg || free_found_reg)) begin
                valid_reg[slot] <= 1'b1;
            end
            if (cmd.ack_clear && cur_valid && acked) begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.give_up) begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.clear_all) begin
                valid_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= s_payload;
            full_reg <= 1'b0;
        end
        if (cmd.scan_start) begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pick_have_reg   <= 1'b0;
        end
        if (cmd.scan_next) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.send_note) begin
            if (cur_valid && (cur_seq == req_reg.sequence_req) && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
            if (!cur_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
        end
        if (cmd.send_write) begin
            if (match_found_reg || free_found_reg) begin
                seq_reg[slot]  <= req_reg.sequence_req;
                time_reg[slot] <= req_reg.now_ms;
                cnt_reg[slot]  <= '0;
            end else begin
                full_reg <= 1'b1;
            end
        end
        if (cmd.tick_start) begin
            visited_reg <= '0;
        end
        if (cmd.pick_note) begin
            if (cur_valid && !visited_reg[idx_reg] &&
                (!pick_have_reg || (cur_seq < pick_seq_reg))) begin
                pick_have_reg <= 1'b1;
                pick_idx_reg  <= idx_reg;
                pick_seq_reg  <= cur_seq;
            end
        end
        if (cmd.pick_go) begin
            idx_reg <= pick_idx_reg;
        end
        if (cmd.eval_visit) begin
            visited_reg[idx_reg] <= 1'b1;
        end
        if (cmd.resend_update) begin
            time_reg[idx_reg] <= req_reg.now_ms;
            cnt_reg[idx_reg]  <= cnt_inc;
        end
        if (cmd.emit) begin
            out_reg <= emit_val;
        end
    end

endmodule

// ===== design/rpat_ctrl.sv =====
// Controller: sequences scans, resend decisions and result emission
module rpat_ctrl import rpat_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEND_SCAN,
        S_SEND_WRITE,
        S_ACK_SCAN,
        S_TICK_SEARCH,
        S_TICK_SELECT,
        S_TICK_EVAL,
        S_TICK_GIVEUP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req   = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (status.action)
                    ACT_SENT:  state_next = status.reliable ? S_SEND_SCAN : S_DONE;
                    ACT_ACK:   state_next = S_ACK_SCAN;
                    ACT_TICK: begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_TICK_SEARCH;
                    end
                    default: begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_DONE;
                    end
                endcase
            end
            S_SEND_SCAN: begin
                cmd.send_note = 1'b1;
                cmd.scan_next = 1'b1;
                if (status.idx_last) begin
                    state_next = S_SEND_WRITE;
                end
            end
            S_SEND_WRITE: begin
                cmd.send_write = 1'b1;
                state_next     = S_DONE;
            end
            S_ACK_SCAN: begin
                cmd.ack_clear = 1'b1;
                cmd.scan_next = 1'b1;
                if (status.idx_last) begin
                    state_next = S_DONE;
                end
            end
            S_TICK_SEARCH: begin
                cmd.pick_note = 1'b1;
                cmd.scan_next = 1'b1;
                if (status.idx_last) begin
                    state_next = S_TICK_SELECT;
                end
            end
            S_TICK_SELECT: begin
                if (status.have_pick) begin
                    cmd.pick_go = 1'b1;
                    state_next  = S_TICK_EVAL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_TICK_EVAL: begin
                if (!status.due) begin
                    cmd.eval_visit = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_TICK_SEARCH;
                end else if (status.out_free) begin
                    cmd.eval_visit = 1'b1;
                    cmd.emit       = 1'b1;
                    if (status.limit_hit) begin
                        cmd.emit_kind  = KIND_GIVE_UP;
                        cmd.give_up    = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_TICK_SEARCH;
                    end else begin
                        cmd.emit_kind     = KIND_RESEND;
                        cmd.resend_update = 1'b1;
                        if (status.limit_next) begin
                            state_next = S_TICK_GIVEUP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_TICK_SEARCH;
                        end
                    end
                end
            end
            S_TICK_GIVEUP: begin
                if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_GIVE_UP;
                    cmd.give_up    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_TICK_SEARCH;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/reliable_packet_ack_tracker.sv =====
// Top level of the reliable packet ack tracker
//
//  port group  direction  handshake           carries
//  s_*         in         s_valid / s_ready   req_t request
//  m_*         out        m_valid / m_ready   rsp_t result
//  cfg_*       in         cfg_valid/cfg_ready register index and data
//
// One request at a time. Reliable sent and ack each make one table scan;
// unreliable sent and clear make none.
// Tick: one min-sequence scan per entry visited plus a last one that finds none;
// a resend that reaches the limit adds a give-up step in S_TICK_GIVEUP.
// A stalled m_ready holds the sequencer at its next result; the input waits
// until the request's last result is in the output register.
// Reset empties the table and loads the register defaults.
`include "reliable_packet_ack_tracker_defines.svh"
module reliable_packet_ack_tracker import rpat_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_payload,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rpat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpat_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    `RPAT_ASSERT(a_busy_after_req, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `RPAT_ASSERT_IMPLY(a_last_is_done, aclk, aresetn,
        m_valid && m_payload.last, m_payload.kind == KIND_DONE)
    `RPAT_ASSERT_IMPLY(a_done_is_last, aclk, aresetn,
        m_valid && (m_payload.kind == KIND_DONE), m_payload.last)
    `RPAT_ASSERT_IMPLY(a_full_on_done, aclk, aresetn,
        m_valid && m_payload.table_full, m_payload.last)

endmodule

// ===== tb/tb.sv =====
// Testbench for the reliable packet ack tracker: directed table, then random phases
module tb;
    import rpat_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);
    localparam int HOLD_CYCLES = 400;
    localparam int MODE_NONE = 0, MODE_SEND = 1, MODE_RECV = 2, MODE_BOTH = 3;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] seq;
        logic [31:0] bits;
        logic        rel;
        logic [47:0] now;
        int          reps;
        bit          typed;
        logic        full;
    } dir_row_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    req_t s_payload;
    rsp_t m_payload;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    reliable_packet_ack_tracker u_top (.*);

    // tracker state as predicted
    bit          tbl_valid[TABLE_DEPTH];
    logic [31:0] tbl_seq[TABLE_DEPTH];
    logic [47:0] tbl_time[TABLE_DEPTH];
    logic [7:0]  tbl_count[TABLE_DEPTH];
    logic [15:0] interval_ms;
    logic [7:0]  resend_limit;

    rsp_t pending_rsp[$];
    int   errs = 0;
    int   mode = MODE_NONE;
    bit   hold_req = 0;
    int   hold_left = 0;

    dir_row_t dir_tab[12] = '{
        '{ACT_SENT,  32'h0,        32'h0,        1'b1, 48'h0,            1,  1, 1'b0},
        '{ACT_SENT,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 48'hFFFFFFFFFFFF, 1,  1, 1'b0},
        '{ACT_SENT,  32'd100,      32'h0,        1'b1, 48'd50,           14, 1, 1'b0},
        '{ACT_SENT,  32'd500,      32'h0,        1'b1, 48'd60,           1,  1, 1'b1},
        '{ACT_SENT,  32'd100,      32'h0,        1'b1, 48'd2000,         1,  1, 1'b0},
        '{ACT_SENT,  32'd600,      32'h0,        1'b0, 48'd70,           1,  1, 1'b0},
        '{ACT_TICK,  32'h0,        32'h0,        1'b0, 48'd1200,         1,  0, 1'b0},
        '{ACT_ACK,   32'd110,      32'hFFFFFFFF, 1'b0, 48'd1300,         1,  1, 1'b0},
        '{ACT_ACK,   32'hFFFFFFFF, 32'h0,        1'b1, 48'd1300,         1,  1, 1'b0},
        '{ACT_ACK,   32'd5,        32'h10,       1'b0, 48'd1300,         1,  1, 1'b0},
        '{ACT_TICK,  32'h0,        32'h0,        1'b1, 48'hFFFFFFFFFFFF, 1,  0, 1'b0},
        '{ACT_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 48'hFFFFFFFFFFFF, 1,  1, 1'b0}
    };

    logic [15:0] intv_set[6] = '{16'd1000, 16'd0, 16'd65535, 16'd0, 16'd300, 16'd2000};
    logic [7:0]  max_set[6]  = '{8'd5, 8'd0, 8'd255, 8'd3, 8'd1, 8'd2};

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit covered_by_ack(logic [31:0] s, logic [31:0] ack, logic [31:0] bits);
        logic [31:0] behind;
        if (s > ack) return 0;
        if (s == ack) return 1;
        behind = ack - s;
        if (behind > ACK_WINDOW) return 0;
        return bits[behind - 1];
    endfunction

    function automatic void put_rsp(logic [1:0] k, logic [31:0] s, logic [7:0] n);
        rsp_t r;
        r.kind = k;
        r.out_sequence = s;
        r.attempt = n;
        r.table_full = 0;
        r.last = 0;
        pending_rsp.push_back(r);
    endfunction

    // returns 1 when the table was full for a new sequence
    function automatic logic track_request(req_t r);
        int slot;
        int pick;
        bit seen[TABLE_DEPTH];
        logic [47:0] elapsed;
        slot = -1;
        case (r.action)
            ACT_SENT: begin
                if (!r.reliable) return 0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (slot < 0 && tbl_valid[i] && tbl_seq[i] == r.sequence_req) slot = i;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                if (slot < 0) return 1;
                tbl_valid[slot] = 1;
                tbl_seq[slot] = r.sequence_req;
                tbl_time[slot] = r.now_ms;
                tbl_count[slot] = 0;
            end
            ACT_ACK: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_valid[i] && covered_by_ack(tbl_seq[i], r.sequence_req, r.ack_bits))
                        tbl_valid[i] = 0;
            end
            ACT_TICK: begin
                for (int i = 0; i < TABLE_DEPTH; i++) seen[i] = 0;
                for (int n = 0; n < TABLE_DEPTH; n++) begin
                    pick = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (tbl_valid[i] && !seen[i] && (pick < 0 || tbl_seq[i] < tbl_seq[pick]))
                            pick = i;
                    if (pick < 0) break;
                    seen[pick] = 1;
                    elapsed = (r.now_ms > tbl_time[pick]) ? r.now_ms - tbl_time[pick] : 48'd0;
                    if (elapsed < interval_ms) continue;
                    if (tbl_count[pick] >= resend_limit) begin
                        put_rsp(KIND_GIVE_UP, tbl_seq[pick], tbl_count[pick]);
                        tbl_valid[pick] = 0;
                        continue;
                    end
                    tbl_time[pick] = r.now_ms;
                    tbl_count[pick] = tbl_count[pick] + 8'd1;
                    put_rsp(KIND_RESEND, tbl_seq[pick], tbl_count[pick]);
                    if (tbl_count[pick] >= resend_limit) begin
                        put_rsp(KIND_GIVE_UP, tbl_seq[pick], tbl_count[pick]);
                        tbl_valid[pick] = 0;
                    end
                end
            end
            default: begin
                for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 0;
            end
        endcase
        return 0;
    endfunction

    // drives one request; typed_full < 0 means the done marker comes from the predictor
    task automatic send_request(req_t r, int typed_full);
        rsp_t done;
        logic full;
        s_valid <= 1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        full = track_request(r);
        done.kind = KIND_DONE;
        done.out_sequence = 0;
        done.attempt = 0;
        done.table_full = (typed_full >= 0) ? logic'(typed_full) : full;
        done.last = 1;
        pending_rsp.push_back(done);
        if ((mode == MODE_SEND && $urandom_range(0, 99) < 57) ||
            (mode == MODE_BOTH && $urandom_range(0, 99) < 27)) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == CFG_INTERVAL) interval_ms = val;
        else if (idx == CFG_MAX_RESENDS) resend_limit = val[7:0];
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (TABLE_DEPTH * (TABLE_DEPTH + 2) + 40) @(posedge aclk);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else if (mode == MODE_RECV) begin
            m_ready <= ($urandom_range(0, 99) >= 57);
        end else if (mode == MODE_BOTH) begin
            m_ready <= ($urandom_range(0, 99) >= 27);
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result kind=%0d seq=%h", m_payload.kind, m_payload.out_sequence);
                errs++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_payload.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_payload.kind);
                    errs++;
                end
                if (m_payload.out_sequence !== want.out_sequence) begin
                    $error("out_sequence: expected %h, got %h",
                           want.out_sequence, m_payload.out_sequence);
                    errs++;
                end
                if (m_payload.attempt !== want.attempt) begin
                    $error("attempt: expected %0d, got %0d", want.attempt, m_payload.attempt);
                    errs++;
                end
                if (m_payload.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, m_payload.table_full);
                    errs++;
                end
                if (m_payload.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_payload.last);
                    errs++;
                end
            end
        end
    end

    initial begin
        #(12 * 1500000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        req_t r;
        logic [31:0] seq_base;
        logic [47:0] clk_ms;
        int pick;
        aresetn = 0;
        s_valid = 0;
        s_payload = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        m_ready = 0;
        interval_ms = INTERVAL_RESET;
        resend_limit = MAX_RESET;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (dir_tab[t]) begin
            for (int j = 0; j < dir_tab[t].reps; j++) begin
                r.action = dir_tab[t].act;
                r.sequence_req = dir_tab[t].seq + j;
                r.ack_bits = dir_tab[t].bits;
                r.reliable = dir_tab[t].rel;
                r.now_ms = dir_tab[t].now;
                send_request(r, dir_tab[t].typed ? int'(dir_tab[t].full) : -1);
            end
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_INTERVAL, intv_set[ph]);
            write_reg(CFG_MAX_RESENDS, {8'($urandom), max_set[ph]});
            if (ph == 2) write_reg(CFG_UNUSED, 16'($urandom));
            mode = ph % 4;
            seq_base = (ph == 3) ? 32'hFFFFFFC0 : $urandom;
            clk_ms = {16'($urandom), 32'($urandom)};
            for (int n = 0; n < 50; n++) begin
                if (ph == 1 && n == 10) hold_req = 1;
                if (ph == 4 && n == 25) drain();
                pick = $urandom_range(0, 99);
                clk_ms += $urandom_range(0, 1200);
                r.action = (pick < 45) ? ACT_SENT : (pick < 65) ? ACT_ACK :
                           (pick < 95) ? ACT_TICK : ACT_CLEAR;
                r.sequence_req = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                               : seq_base + $urandom_range(0, 40);
                case ($urandom_range(0, 5))
                    0: r.ack_bits = 32'h0;
                    1: r.ack_bits = 32'hFFFFFFFF;
                    default: r.ack_bits = $urandom;
                endcase
                r.reliable = (r.action == ACT_SENT) ? ($urandom_range(0, 99) < 85)
                                                    : 1'($urandom);
                r.now_ms = ($urandom_range(0, 9) == 0) ? clk_ms - $urandom_range(0, 3000)
                                                       : clk_ms;
                send_request(r, -1);
            end
            drain();
        end

        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
